FILE: hdl/psct_pkg.sv
// ----------------------------------------------------------------------------
// psct_pkg: shared types and constants of the planar shape collision test
// Kind codes, test modes, word layout and fixed point helpers.
// ----------------------------------------------------------------------------
package psct_pkg;

    localparam int COORD_BITS = 32;
    localparam int COORD_W    = (COORD_BITS < 32) ? COORD_BITS : 32;

    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NPTS   = 4;

    localparam logic [30:0] SHORT_LEN_RST = 31'd655360;
    localparam logic [30:0] LONG_LEN_RST  = 31'd6553600;
    localparam logic [15:0] TOL_RST       = 16'd66;

    typedef enum logic [2:0] {
        KIND_BOX       = 3'd0,
        KIND_CIRCLE    = 3'd1,
        KIND_DISABLED  = 3'd2,
        KIND_SHORT     = 3'd3,
        KIND_LONG      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SHORT_LEN = 2'd0,
        CFG_LONG_LEN  = 2'd1,
        CFG_TOL       = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    // final decision taken for one word
    typedef enum logic [2:0] {
        MODE_FALSE,
        MODE_TRUE,
        MODE_BOX,
        MODE_CIRC,
        MODE_LPT,
        MODE_LBOX
    } t_mode;

    typedef logic signed [31:0]   t_coord;
    typedef logic signed [OP_W-1:0] t_op;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0] t_sum;

    // per word control carried down the pipeline
    typedef struct packed {
        t_mode                mode;
        logic                 flag;
        logic                 r_pos;
        logic signed [33:0]   lc;
        logic signed [33:0]   ld;
        logic signed [33:0]   half;
        logic signed [33:0]   lower;
        logic signed [33:0]   upper;
    } t_ctl;

    function automatic t_coord sext_coord(input logic [31:0] v);
        logic [31:0] m;
        m = 32'(1) << (COORD_W - 1);
        return t_coord'((v & (m - 32'(1))) - (v & m));
    endfunction

    // value in Q16.16 lifted to the Q32.32 scale of the sums
    function automatic t_sum q_lift(input logic signed [33:0] v);
        return {{(SUM_W - 50){v[33]}}, v, 16'h0000};
    endfunction

    function automatic t_sum p_ext(input t_prod p);
        return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic logic is_line(input logic [2:0] k);
        return k >= 3'(KIND_SHORT);
    endfunction

endpackage

FILE: hdl/planar_shape_collision_test.sv
// ----------------------------------------------------------------------------
// planar_shape_collision_test: pair collision test for planar shapes
// Box, circle, disabled circle and short or long lines in signed Q16.16.
// ----------------------------------------------------------------------------
// Input stream (i_s_*): one word per shape pair or shape and point test.
// Output stream (o_m_*): one word per input word, in order, bit 0 = hit.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 short line reach, 1 long line reach, 2 on-line tolerance); write only
//   while the block is idle.
// Path: a word accepted on the input passes the input register, operand
//   stage, multiply stage, then sums and compares into the output register.
// Throughput: one word per cycle while the output is not stalled, set by
//   the four stage pipeline with a bank of 17 parallel 33x33 multipliers.
// Stall: every stage holds while the one below it is full and blocked;
//   empty stages still fill, so up to four words sit inside when stalled.
// Reset: i_rst_n low clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module planar_shape_collision_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // func, first_kind, first_a..d, second_kind, second_a..d, zero pad
    input  logic [psct_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // hit, zero pad
    output logic [psct_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [psct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psct_pkg::*;

    logic [30:0] r_short_len, r_long_len;
    logic [15:0] r_tol;

    logic                  r_v_in, r_v_ops, r_v_prod, r_v_out;
    logic [IN_DATA_W-1:0]  r_in;
    t_op                   r_opa [NPTS][4];
    t_op                   r_opb [NPTS][4];
    t_op                   r_rad;
    t_ctl                  r_ctl_ops, r_ctl_prod;
    t_prod                 r_prod [NPTS][4];
    t_prod                 r_rsq;
    logic                  r_hit;

    logic en_out, en_prod, en_ops, en_in;
    assign en_out  = !r_v_out || i_m_tready;
    assign en_prod = en_out || !r_v_prod;
    assign en_ops  = en_prod || !r_v_ops;
    assign en_in   = en_ops || !r_v_in;
    assign o_s_tready = en_in;
    assign o_m_tvalid = r_v_out;
    assign o_m_tdata  = {{(OUT_DATA_W - 1){1'b0}}, r_hit};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_len <= SHORT_LEN_RST;
            r_long_len  <= LONG_LEN_RST;
            r_tol       <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT_LEN: r_short_len <= i_cfg_data;
                CFG_LONG_LEN:  r_long_len  <= i_cfg_data;
                CFG_TOL:       r_tol       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // operand selection
    logic        func;
    logic [2:0]  k1, k2;
    t_coord      a1, b1, c1, d1, a2, b2, c2, d2;
    t_coord      px [NPTS];
    t_coord      pz [NPTS];
    t_coord      la, lb, ca, cb, ba, bb, bc, bd;
    logic signed [32:0] rad;
    logic [30:0] reach;
    logic        circ_mode;
    t_ctl        n_ctl;
    t_op         n_opa [NPTS][4];
    t_op         n_opb [NPTS][4];
    logic signed [32:0] dx, dz;

    always_comb begin
        func = r_in[0];
        k1   = r_in[3:1];
        a1   = sext_coord(r_in[35:4]);
        b1   = sext_coord(r_in[67:36]);
        c1   = sext_coord(r_in[99:68]);
        d1   = sext_coord(r_in[131:100]);
        k2   = r_in[134:132];
        a2   = sext_coord(r_in[166:135]);
        b2   = sext_coord(r_in[198:167]);
        c2   = sext_coord(r_in[230:199]);
        d2   = sext_coord(r_in[262:231]);

        n_ctl       = '0;
        n_ctl.mode  = MODE_FALSE;
        circ_mode   = 1'b0;
        rad         = '0;
        la = '0; lb = '0; ca = '0; cb = '0;
        ba = a1; bb = b1; bc = c1; bd = d1;
        reach = r_long_len;
        for (int i = 0; i < NPTS; i++) begin
            px[i] = a2;
            pz[i] = b2;
        end

        if (func) begin
            unique case (k1)
                3'(KIND_BOX): begin
                    n_ctl.mode = MODE_BOX;
                    n_ctl.flag = (a1 < a2) && (a2 < c1) && (b1 < b2) && (b2 < d1);
                end
                3'(KIND_CIRCLE): begin
                    n_ctl.mode = MODE_CIRC;
                    circ_mode  = 1'b1;
                    ca = a1; cb = b1; rad = 33'(c1);
                end
                3'(KIND_DISABLED): n_ctl.mode = MODE_FALSE;
                default: begin
                    n_ctl.mode  = MODE_LPT;
                    la = a1; lb = b1;
                    n_ctl.lc    = 34'(c1);
                    n_ctl.ld    = 34'(d1);
                    reach       = (k1 == 3'(KIND_SHORT)) ? r_short_len : r_long_len;
                    n_ctl.half  = 34'(signed'({1'b0, r_tol}));
                    n_ctl.upper = 34'(signed'({1'b0, reach}));
                end
            endcase
        end else if (k1 == 3'(KIND_DISABLED) || k2 == 3'(KIND_DISABLED)) begin
            n_ctl.mode = MODE_FALSE;
        end else if (k1 == 3'(KIND_BOX) && k2 == 3'(KIND_BOX)) begin
            n_ctl.mode = MODE_BOX;
            n_ctl.flag = (a1 < c2) && (a2 < c1) && (b1 < d2) && (b2 < d1);
        end else if (k1 == 3'(KIND_CIRCLE) && k2 == 3'(KIND_CIRCLE)) begin
            n_ctl.mode = MODE_CIRC;
            circ_mode  = 1'b1;
            ca = a1; cb = b1;
            rad = 33'(c1) + 33'(c2);
        end else if (is_line(k1) && is_line(k2)) begin
            n_ctl.mode = MODE_TRUE;
        end else begin
            // one side is a box or circle, pick the roles
            if (k1 == 3'(KIND_BOX)) begin
                ba = a1; bb = b1; bc = c1; bd = d1;
            end else if (k2 == 3'(KIND_BOX)) begin
                ba = a2; bb = b2; bc = c2; bd = d2;
            end
            if (k1 == 3'(KIND_CIRCLE)) begin
                ca = a1; cb = b1; rad = 33'(c1);
            end else begin
                ca = a2; cb = b2; rad = 33'(c2);
            end
            if (is_line(k1)) begin
                la = a1; lb = b1;
                n_ctl.lc = 34'(c1); n_ctl.ld = 34'(d1);
                reach = (k1 == 3'(KIND_SHORT)) ? r_short_len : r_long_len;
            end else begin
                la = a2; lb = b2;
                n_ctl.lc = 34'(c2); n_ctl.ld = 34'(d2);
                reach = (k2 == 3'(KIND_SHORT)) ? r_short_len : r_long_len;
            end
            px[0] = ba; pz[0] = bb;
            px[1] = ba; pz[1] = bd;
            px[2] = bc; pz[2] = bb;
            px[3] = bc; pz[3] = bd;
            if (k1 == 3'(KIND_CIRCLE) || k2 == 3'(KIND_CIRCLE)) begin
                if (k1 == 3'(KIND_BOX) || k2 == 3'(KIND_BOX)) begin
                    n_ctl.mode = MODE_CIRC;
                    circ_mode  = 1'b1;
                    n_ctl.lc   = '0;
                    n_ctl.flag = (ba < ca) && (ca < bc) && (bb < cb) && (cb < bd);
                end else begin
                    n_ctl.mode  = MODE_LPT;
                    for (int i = 0; i < NPTS; i++) begin
                        px[i] = ca;
                        pz[i] = cb;
                    end
                    n_ctl.half  = 34'(rad);
                    n_ctl.lower = -34'(rad);
                    n_ctl.upper = 34'(rad) + 34'(signed'({1'b0, reach}));
                end
            end else begin
                n_ctl.mode  = MODE_LBOX;
                n_ctl.upper = 34'(signed'({1'b0, reach}));
            end
        end
        n_ctl.r_pos = rad > 33'sd0;

        for (int i = 0; i < NPTS; i++) begin
            dx = 33'(ca) - 33'(px[i]);
            dz = 33'(cb) - 33'(pz[i]);
            if (circ_mode) begin
                n_opa[i][0] = dx;        n_opb[i][0] = dx;
                n_opa[i][1] = dz;        n_opb[i][1] = dz;
                n_opa[i][2] = '0;        n_opb[i][2] = '0;
                n_opa[i][3] = '0;        n_opb[i][3] = '0;
            end else begin
                n_opa[i][0] = 33'(px[i]); n_opb[i][0] = 33'(la);
                n_opa[i][1] = 33'(pz[i]); n_opb[i][1] = 33'(lb);
                n_opa[i][2] = 33'(px[i]); n_opb[i][2] = 33'(lb);
                n_opa[i][3] = 33'(pz[i]); n_opb[i][3] = 33'(la);
            end
        end
    end

    // sums and compares
    t_sum across [NPTS];
    t_sum along  [NPTS];
    logic [NPTS-1:0] in_circ, band, in_range, side;
    logic n_hit;

    always_comb begin
        for (int i = 0; i < NPTS; i++) begin
            across[i]   = p_ext(r_prod[i][0]) + p_ext(r_prod[i][1]) + q_lift(r_ctl_prod.lc);
            along[i]    = p_ext(r_prod[i][2]) - p_ext(r_prod[i][3]) + q_lift(r_ctl_prod.ld);
            in_circ[i]  = across[i] < p_ext(r_rsq);
            band[i]     = (-q_lift(r_ctl_prod.half) < across[i])
                          && (across[i] < q_lift(r_ctl_prod.half));
            in_range[i] = (q_lift(r_ctl_prod.lower) < along[i])
                          && (along[i] < q_lift(r_ctl_prod.upper));
            side[i]     = across[i] > t_sum'(0);
        end
        unique case (r_ctl_prod.mode)
            MODE_TRUE: n_hit = 1'b1;
            MODE_BOX:  n_hit = r_ctl_prod.flag;
            MODE_CIRC: n_hit = r_ctl_prod.flag || (r_ctl_prod.r_pos && (|in_circ));
            MODE_LPT:  n_hit = band[0] && in_range[0];
            MODE_LBOX: n_hit = !((&side) || !(|side)) && (|in_range);
            default:   n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_ops  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (en_in)   r_v_in   <= i_s_tvalid;
            if (en_ops)  r_v_ops  <= r_v_in;
            if (en_prod) r_v_prod <= r_v_ops;
            if (en_out)  r_v_out  <= r_v_prod;
        end
        if (en_in) r_in <= i_s_tdata;
        if (en_ops) begin
            r_opa     <= n_opa;
            r_opb     <= n_opb;
            r_rad     <= rad;
            r_ctl_ops <= n_ctl;
        end
        if (en_prod) begin
            for (int i = 0; i < NPTS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= r_opa[i][j] * r_opb[i][j];
                end
            end
            r_rsq      <= r_rad * r_rad;
            r_ctl_prod <= r_ctl_ops;
        end
        if (en_out) r_hit <= n_hit;
    end

endmodule

FILE: hdl/psct_checker.sv
// ----------------------------------------------------------------------------
// psct_checker: port level checks of the planar shape collision test
// Watches the streams of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module psct_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [psct_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import psct_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // only the hit bit may be set
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_DATA_W-1:1] == '0)
        else $error("pad bits of result word set");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

endmodule

bind planar_shape_collision_test psct_checker u_psct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
